// ===== rtl/fwnf_pkg.sv =====
// Shared types and constants for the fixed-width number formatter.
`timescale 1ns / 1ps
`default_nettype none

package fwnf_pkg;

    localparam int MAX_DIGITS      = 10;
    localparam int HEX_DIGIT_LIMIT = 8;

    // Symbol kinds on the result channel
    localparam logic [1:0] KIND_DIGIT    = 2'd0;
    localparam logic [1:0] KIND_PAD      = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;
    localparam logic [1:0] KIND_TERM     = 2'd3;

    // Alignment modes; the unused code behaves as left align
    localparam logic [1:0] ALIGN_LEFT = 2'd0;
    localparam logic [1:0] ALIGN_PAD  = 2'd1;
    localparam logic [1:0] ALIGN_ZERO = 2'd2;

    // Decimal place values, wide enough to hold nine times the top one
    localparam logic [35:0] POW_DEC [MAX_DIGITS] = '{
        36'd1, 36'd10, 36'd100, 36'd1000, 36'd10000, 36'd100000,
        36'd1000000, 36'd10000000, 36'd100000000, 36'd1000000000
    };

    typedef struct packed {
        logic [31:0] value;
        logic        hex_radix;
        logic [1:0]  align_mode;
        logic [3:0]  digit_count;
    } fwnf_in_t;

    typedef struct packed {
        logic [1:0] symbol_kind;
        logic [3:0] digit_value;
        logic       last;
    } fwnf_out_t;

endpackage

`default_nettype wire

// ===== rtl/fixed_width_number_formatter.sv =====
// Throughput: one symbol per cycle unless m_ready stalls the output; a request holds the symbol
// sequencer for its symbols plus the terminator, and that sequencer sets the sustained rate.
// Requests enter a ten-stage digit pipeline plus a prepare stage, one per cycle while free.
// Reset: synchronous, active-low aresetn clears all valid flags and the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module fixed_width_number_formatter (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  fwnf_pkg::fwnf_in_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output fwnf_pkg::fwnf_out_t  m_data
);
    import fwnf_pkg::*;

    localparam int NSTG = MAX_DIGITS;

    typedef struct packed {
        logic [31:0]                 rem;
        logic                        hex;
        logic [1:0]                  mode;
        logic [3:0]                  n;
        logic [MAX_DIGITS-1:0][3:0]  dig;
    } stage_t;

    typedef struct packed {
        logic [MAX_DIGITS-1:0][3:0]  dig;
        logic [1:0]                  mode;
        logic [3:0]                  n;
        logic                        ovf;
        logic [3:0]                  fpos;
        logic [3:0]                  start;
    } prep_t;

    stage_t            st_reg  [NSTG];
    stage_t            st_next [NSTG];
    stage_t            entry_next;
    logic [NSTG-1:0]   st_v_reg;
    logic [NSTG-1:0]   st_en;

    prep_t             prep_reg;
    prep_t             prep_next;
    logic              prep_v_reg;
    logic              prep_en;

    prep_t             ser_reg;
    logic              ser_busy_reg;
    logic              ser_term_reg;
    logic [3:0]        ser_pos_reg;
    logic              ser_load;
    logic              emit;
    logic              slot;
    fwnf_out_t         sym;

    logic              m_valid_reg;
    fwnf_out_t         m_data_reg;

    // Stall chain: a stage loads when empty or when its contents move on
    assign slot     = !m_valid_reg || m_ready;
    assign emit     = ser_busy_reg && slot;
    assign ser_load = prep_v_reg && (!ser_busy_reg || (emit && ser_term_reg));
    assign prep_en  = !prep_v_reg || ser_load;

    always_comb begin
        st_en[NSTG-1] = !st_v_reg[NSTG-1] || prep_en;
        for (int k = NSTG - 2; k >= 0; k--) begin
            st_en[k] = !st_v_reg[k] || st_en[k+1];
        end
    end

    assign s_ready = st_en[0];

    // Entry stage: clamp the digit count
    always_comb begin
        logic [3:0] n;
        n = s_data.digit_count;
        if (n == 4'd0) begin
            n = 4'd1;
        end
        if (n > 4'(MAX_DIGITS)) begin
            n = 4'(MAX_DIGITS);
        end
        if (s_data.hex_radix && (n > 4'(HEX_DIGIT_LIMIT))) begin
            n = 4'(HEX_DIGIT_LIMIT);
        end
        entry_next.rem  = s_data.value;
        entry_next.hex  = s_data.hex_radix;
        entry_next.mode = s_data.align_mode;
        entry_next.n    = n;
        entry_next.dig  = '0;
    end

    // Digit stages: stage k extracts the digit at place MAX_DIGITS-k
    always_comb begin
        logic [35:0] cand;
        logic [35:0] sub;
        logic [3:0]  q;
        logic [39:0] remx;
        st_next[0] = entry_next;
        for (int k = 1; k < NSTG; k++) begin
            st_next[k] = st_reg[k-1];
            sub  = '0;
            q    = '0;
            // places above the value's top nibble read as zero
            remx = {8'd0, st_reg[k-1].rem};
            for (int m = 1; m <= 9; m++) begin
                cand = 36'(m) * POW_DEC[MAX_DIGITS - k];
                if ({4'd0, st_reg[k-1].rem} >= cand) begin
                    sub = cand;
                    q   = 4'(m);
                end
            end
            if (st_reg[k-1].hex) begin
                st_next[k].dig[MAX_DIGITS-k] = remx[4*(MAX_DIGITS-k) +: 4];
            end else begin
                st_next[k].dig[MAX_DIGITS-k] = q;
                st_next[k].rem = st_reg[k-1].rem - sub[31:0];
            end
        end
    end

    // Prepare stage: overflow, first significant place and starting place
    always_comb begin
        logic [MAX_DIGITS-1:0][3:0] d;
        logic                       ovf;
        logic [3:0]                 fpos;
        d      = st_reg[NSTG-1].dig;
        d[0]   = st_reg[NSTG-1].rem[3:0];
        ovf    = 1'b0;
        fpos   = 4'd0;
        for (int j = 0; j < MAX_DIGITS; j++) begin
            if (4'(j) >= st_reg[NSTG-1].n) begin
                if (d[j] != 4'd0) begin
                    ovf = 1'b1;
                end
            end else if (d[j] != 4'd0) begin
                fpos = 4'(j);
            end
        end
        prep_next.dig  = d;
        prep_next.mode = st_reg[NSTG-1].mode;
        prep_next.n    = st_reg[NSTG-1].n;
        prep_next.ovf  = ovf;
        prep_next.fpos = fpos;
        if (!ovf && (st_reg[NSTG-1].mode != ALIGN_PAD) && (st_reg[NSTG-1].mode != ALIGN_ZERO)) begin
            prep_next.start = fpos;
        end else begin
            prep_next.start = st_reg[NSTG-1].n - 4'd1;
        end
    end

    // Symbol for the current place
    always_comb begin
        sym = '0;
        if (ser_term_reg) begin
            sym.symbol_kind = KIND_TERM;
            sym.last        = 1'b1;
        end else if (ser_reg.ovf && (ser_pos_reg == ser_reg.n - 4'd1)) begin
            sym.symbol_kind = KIND_OVERFLOW;
        end else if ((ser_reg.mode == ALIGN_PAD) && !ser_reg.ovf && (ser_pos_reg > ser_reg.fpos)) begin
            sym.symbol_kind = KIND_PAD;
        end else begin
            sym.symbol_kind = KIND_DIGIT;
            sym.digit_value = ser_reg.dig[ser_pos_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_v_reg     <= '0;
            prep_v_reg   <= 1'b0;
            ser_busy_reg <= 1'b0;
            ser_term_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (st_en[k]) begin
                    st_v_reg[k] <= (k == 0) ? s_valid : st_v_reg[(k == 0) ? 0 : k - 1];
                end
            end
            if (prep_en) begin
                prep_v_reg <= st_v_reg[NSTG-1];
            end
            if (slot) begin
                m_valid_reg <= emit;
            end
            // Load the next request when idle or as the terminator leaves, else advance one place
            if (ser_load) begin
                ser_busy_reg <= 1'b1;
                ser_term_reg <= 1'b0;
            end else if (emit) begin
                if (ser_term_reg) begin
                    ser_busy_reg <= 1'b0;
                end else if (ser_pos_reg == 4'd0) begin
                    ser_term_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (st_en[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
        if (prep_en) begin
            prep_reg <= prep_next;
        end
        if (emit) begin
            m_data_reg <= sym;
        end
        if (ser_load) begin
            ser_reg     <= prep_reg;
            ser_pos_reg <= prep_reg.start;
        end else if (emit && !ser_term_reg && (ser_pos_reg != 4'd0)) begin
            ser_pos_reg <= ser_pos_reg - 4'd1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTH
    a_last_on_term: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.symbol_kind == KIND_TERM)))
        else $error("last flag does not match terminator");

    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.symbol_kind != KIND_DIGIT)) |-> (m_data.digit_value == 4'd0))
        else $error("non-digit symbol carries a digit value");

    a_pos_in_field: assert property (@(posedge aclk) disable iff (!aresetn)
        (ser_busy_reg && !ser_term_reg) |-> (ser_pos_reg < ser_reg.n))
        else $error("sequencer place outside the field");

    a_ovf_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (prep_v_reg && prep_reg.ovf) |-> (prep_reg.start == prep_reg.n - 4'd1))
        else $error("overflow request does not start at the top place");
`endif

endmodule

`default_nettype wire
